FILE: hdl/sleb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sleb_pkg
// Shared types and command codes for the single-line edit buffer.
// ----------------------------------------------------------------------------
package sleb_pkg;

  localparam int KIND_W  = 4;
  localparam int CHAR_W  = 8;
  localparam int POS_W   = 6;
  localparam int TDATA_W = 24;

  localparam logic [KIND_W-1:0] KIND_CHAR      = 4'd0;
  localparam logic [KIND_W-1:0] KIND_BACKSPACE = 4'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_LEFT      = 4'd3;
  localparam logic [KIND_W-1:0] KIND_RIGHT     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_HOME      = 4'd5;
  localparam logic [KIND_W-1:0] KIND_END       = 4'd6;
  localparam logic [KIND_W-1:0] KIND_TOGGLE    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_ENTER     = 4'd8;

  localparam logic [POS_W-1:0] MAX_LENGTH_RST = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_EMIT,
    ST_RESULT
  } state_t;

endpackage

FILE: hdl/single_line_edit_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_line_edit_buffer
// One-line character buffer with cursor and insert/overwrite mode, driven by
// edit commands; enter streams the line out and clears it.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser kind, tdata char_code
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata status+char, tuser has_char,
//                                               tlast last
// cfg       in   cfg_we                         cfg_wdata max_length
//
// Steps: cursor moves, home, end, toggle and refused commands go straight to
// the result. Insert places the character at once at the line end, else it
// first shifts the tail up; backspace and delete shift the tail down only when
// one follows the removed character, each by a walk through the line memory
// over its read and write ports. Enter gives one result per cycle unless m_axis stalls.
// Reset: synchronous; the memory needs no clearing, the length bounds reads.
// Stalls: the result register holds; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module single_line_edit_buffer #(
  parameter int LINE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] char_code
  input  logic [3:0]                  s_axis_tuser,   // [3:0] kind
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] char_out, [8] rejected, [14:9] cursor_now, [20:15] length_now,
  // [21] insert_mode_now, [23:22] zero
  output logic [sleb_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tuser,   // [0] has_char
  output logic                        m_axis_tlast,
  input  logic                        cfg_we,
  input  logic [5:0]                  cfg_wdata       // max_length
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [sleb_pkg::POS_W-1:0] DEPTH_CAP =
    (LINE_DEPTH > 63) ? 6'd63 : 6'(LINE_DEPTH);

  sleb_pkg::state_t state, state_next;

  logic [sleb_pkg::POS_W-1:0]  max_length;
  logic [sleb_pkg::POS_W-1:0]  cursor;
  logic [sleb_pkg::POS_W-1:0]  line_length;
  logic                        insert_mode;
  logic                        rej;
  logic [sleb_pkg::CHAR_W-1:0] ch_reg;
  logic [sleb_pkg::POS_W-1:0]  ptr;
  logic [sleb_pkg::POS_W-1:0]  remain;
  logic [sleb_pkg::POS_W-1:0]  left;
  logic                        shift_up;
  logic                        pend;
  logic [sleb_pkg::POS_W-1:0]  pend_addr;
  logic                        fetched;

  logic [7:0]    mem [LINE_DEPTH];
  logic [7:0]    mem_rdata;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  logic                        s_fire;
  logic                        out_free;
  logic                        out_load;
  logic                        issue;
  logic [sleb_pkg::POS_W-1:0]  lim;
  logic [sleb_pkg::KIND_W-1:0] kind;
  logic [sleb_pkg::POS_W-1:0]  del_pos;
  logic                        acc_rej;
  sleb_pkg::state_t            acc_state;

  logic [7:0]                  out_char;
  logic                        out_has;
  logic                        out_last;

  assign kind     = s_axis_tuser;
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign lim      = (max_length > DEPTH_CAP) ? DEPTH_CAP : max_length;
  assign del_pos  = (kind == sleb_pkg::KIND_BACKSPACE) ? cursor - 6'd1 : cursor;

  // command decode at accept
  always_comb begin
    acc_rej   = 1'b0;
    acc_state = sleb_pkg::ST_RESULT;
    unique case (kind)
      sleb_pkg::KIND_CHAR: begin
        if (insert_mode) begin
          if (line_length >= lim) begin
            acc_rej = 1'b1;
          end else if (line_length > cursor) begin
            acc_state = sleb_pkg::ST_SHIFT;
          end else begin
            acc_state = sleb_pkg::ST_PLACE;
          end
        end else if (cursor >= lim) begin
          acc_rej = 1'b1;
        end else begin
          acc_state = sleb_pkg::ST_PLACE;
        end
      end
      sleb_pkg::KIND_BACKSPACE: begin
        if (cursor == '0) begin
          acc_rej = 1'b1;
        end else if (line_length - 6'd1 != del_pos) begin
          acc_state = sleb_pkg::ST_SHIFT;
        end
      end
      sleb_pkg::KIND_DELETE: begin
        if (cursor >= line_length) begin
          acc_rej = 1'b1;
        end else if (line_length - 6'd1 != del_pos) begin
          acc_state = sleb_pkg::ST_SHIFT;
        end
      end
      sleb_pkg::KIND_LEFT:  acc_rej = (cursor == '0);
      sleb_pkg::KIND_RIGHT: acc_rej = (cursor >= line_length);
      sleb_pkg::KIND_ENTER: begin
        if (line_length != '0) begin
          acc_state = sleb_pkg::ST_EMIT;
        end
      end
      default: acc_state = sleb_pkg::ST_RESULT;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sleb_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_next = acc_state;
        end
      end
      sleb_pkg::ST_SHIFT: begin
        if (remain == '0 && !pend) begin
          state_next = shift_up ? sleb_pkg::ST_PLACE : sleb_pkg::ST_RESULT;
        end
      end
      sleb_pkg::ST_PLACE:  state_next = sleb_pkg::ST_RESULT;
      sleb_pkg::ST_EMIT: begin
        if (out_load && left == 6'd1) begin
          state_next = sleb_pkg::ST_IDLE;
        end
      end
      sleb_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = sleb_pkg::ST_IDLE;
        end
      end
      default: state_next = sleb_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = AW'(pend_addr);
    mem_raddr = AW'(ptr);
    mem_wdata = mem_rdata;
    out_load  = 1'b0;
    out_char  = '0;
    out_has   = 1'b0;
    out_last  = 1'b1;
    issue     = 1'b0;
    unique case (state)
      sleb_pkg::ST_IDLE: s_axis_tready = 1'b1;
      sleb_pkg::ST_SHIFT: begin
        mem_re = (remain != '0);
        mem_we = pend;
      end
      sleb_pkg::ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cursor);
        mem_wdata = ch_reg;
      end
      sleb_pkg::ST_EMIT: begin
        out_load = fetched && out_free;
        issue    = (remain != '0) && (!fetched || out_load);
        mem_re   = issue;
        out_char = mem_rdata;
        out_has  = 1'b1;
        out_last = (left == 6'd1);
      end
      sleb_pkg::ST_RESULT: out_load = out_free;
      default: s_axis_tready = 1'b0;
    endcase
  end

  // line memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= sleb_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      max_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sleb_pkg::ST_IDLE;
      cursor      <= '0;
      line_length <= '0;
      insert_mode <= 1'b1;
      rej         <= 1'b0;
      remain      <= '0;
      pend        <= 1'b0;
      fetched     <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        sleb_pkg::ST_IDLE: begin
          if (s_fire) begin
            rej    <= acc_rej;
            ch_reg <= s_axis_tdata;
            pend   <= 1'b0;
            unique case (kind)
              sleb_pkg::KIND_CHAR: begin
                shift_up <= 1'b1;
                ptr      <= line_length - 6'd1;
                remain   <= line_length - cursor;
              end
              sleb_pkg::KIND_BACKSPACE, sleb_pkg::KIND_DELETE: begin
                if (!acc_rej) begin
                  shift_up    <= 1'b0;
                  cursor      <= del_pos;
                  ptr         <= del_pos + 6'd1;
                  remain      <= line_length - 6'd1 - del_pos;
                  line_length <= line_length - 6'd1;
                end
              end
              sleb_pkg::KIND_LEFT: begin
                if (!acc_rej) cursor <= cursor - 6'd1;
              end
              sleb_pkg::KIND_RIGHT: begin
                if (!acc_rej) cursor <= cursor + 6'd1;
              end
              sleb_pkg::KIND_HOME:   cursor <= '0;
              sleb_pkg::KIND_END:    cursor <= line_length;
              sleb_pkg::KIND_TOGGLE: insert_mode <= !insert_mode;
              sleb_pkg::KIND_ENTER: begin
                ptr         <= '0;
                remain      <= line_length;
                left        <= line_length;
                fetched     <= 1'b0;
                cursor      <= '0;
                line_length <= '0;
              end
              default: ;
            endcase
          end
        end
        sleb_pkg::ST_SHIFT: begin
          if (remain != '0) begin
            ptr       <= shift_up ? ptr - 6'd1 : ptr + 6'd1;
            pend_addr <= shift_up ? ptr + 6'd1 : ptr - 6'd1;
            remain    <= remain - 6'd1;
            pend      <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        sleb_pkg::ST_PLACE: begin
          cursor <= cursor + 6'd1;
          if (insert_mode) begin
            line_length <= line_length + 6'd1;
          end else if (cursor + 6'd1 > line_length) begin
            line_length <= cursor + 6'd1;
          end
        end
        sleb_pkg::ST_EMIT: begin
          if (issue) begin
            ptr    <= ptr + 6'd1;
            remain <= remain - 6'd1;
          end
          if (out_load) begin
            left <= left - 6'd1;
          end
          fetched <= issue ? 1'b1 : (out_load ? 1'b0 : fetched);
        end
        sleb_pkg::ST_RESULT: begin
          rej <= rej;
        end
        default: rej <= 1'b0;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {2'b00, insert_mode, line_length, cursor,
                       (state == sleb_pkg::ST_RESULT) ? rej : 1'b0, out_char};
      m_axis_tuser <= out_has;
      m_axis_tlast <= out_last;
    end
  end

  // checks
  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    cursor <= line_length)
    else $error("cursor beyond line end");

  a_length_cap: assert property (@(posedge clk) disable iff (rst)
    line_length <= DEPTH_CAP)
    else $error("line length beyond capacity");

  a_mem_port_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write at one address");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten before taken");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_axis_tready)
    else $error("request taken while busy");

endmodule
